// ===== design/pgdn_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pgdn_pkg;

	// Calendar range and field widths.
	localparam int MAX_YEAR = 9999;
	localparam int DAYS_W   = 22;
	localparam int COUNT_W  = 23;
	localparam int YEAR_W   = 14;
	localparam int MONTH_W  = 4;
	localparam int DAY_W    = 5;

	// Day number of 31.12.MAX_YEAR.
	localparam int LAST_DAY = 365 * MAX_YEAR + MAX_YEAR / 4 - MAX_YEAR / 100 + MAX_YEAR / 400;

	// Pipeline depth, input register to result register.
	localparam int STAGES = 10;

	typedef enum logic [1:0] {
		OP_DATE_TO_DAYS = 2'd0,
		OP_DAYS_TO_DATE = 2'd1,
		OP_DATE_ADD     = 2'd2,
		OP_DATE_DIFF    = 2'd3
	} pgdn_op_t;

	// Result data that rides along with the day number through the date builder.
	typedef struct packed {
		logic signed [COUNT_W-1:0] count;
		logic                      err;
		logic                      want_date;
	} pgdn_side_t;

	// Days in the year before the first of the given month.
	function automatic logic [8:0] cum_days(input logic [MONTH_W-1:0] m, input logic leap);
		logic [8:0] c;
		case (m)
			4'd1:    c = 9'd0;
			4'd2:    c = 9'd31;
			4'd3:    c = 9'd59;
			4'd4:    c = 9'd90;
			4'd5:    c = 9'd120;
			4'd6:    c = 9'd151;
			4'd7:    c = 9'd181;
			4'd8:    c = 9'd212;
			4'd9:    c = 9'd243;
			4'd10:   c = 9'd273;
			4'd11:   c = 9'd304;
			4'd12:   c = 9'd334;
			default: c = 9'd0;
		endcase
		if (leap && m > 4'd2) begin
			c = c + 9'd1;
		end
		return c;
	endfunction

	function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
		input logic leap);
		logic [DAY_W-1:0] n;
		case (m)
			4'd2:                    n = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
			default:                 n = 5'd31;
		endcase
		return n;
	endfunction

endpackage

`default_nettype wire

// ===== design/proleptic_gregorian_day_number_unit_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                   Beat contents
// item      in         item_valid / item_stall     operation, first date, day_count,
//                                                  second date
// result    out        result_valid / result_stall out_day, out_month, out_year,
//                                                  out_count, error
//
// Every beat passes through the ten-register pipeline (input register, two
// date-to-day stages, one combine stage, six day-to-date stages) to its result beat,
// and a new beat can be taken in every cycle in which item_stall is low.
// arst_n clears the valid bit of every stage; data registers are not reset.
// A stage loads when it is empty or when the stage after it loads, so item_stall
// rises only when every stage holds a beat and result_stall is high.

module proleptic_gregorian_day_number_unit_core import pgdn_pkg::*; (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      item_valid,
	output logic                           item_stall,
	input  wire logic [1:0]                operation,
	input  wire logic [DAY_W-1:0]          day,
	input  wire logic [MONTH_W-1:0]        month,
	input  wire logic [YEAR_W-1:0]         year,
	input  wire logic signed [COUNT_W-1:0] day_count,
	input  wire logic [DAY_W-1:0]          day_b,
	input  wire logic [MONTH_W-1:0]        month_b,
	input  wire logic [YEAR_W-1:0]         year_b,
	output logic                           result_valid,
	input  wire logic                      result_stall,
	output logic [DAY_W-1:0]               out_day,
	output logic [MONTH_W-1:0]             out_month,
	output logic [YEAR_W-1:0]              out_year,
	output logic signed [COUNT_W-1:0]      out_count,
	output logic                           error
);

	// Stage occupancy and load enables. Index 0 is the input register.
	logic [STAGES-1:0] valid_q;
	logic [STAGES-1:0] load;

	always_comb begin
		load[STAGES-1] = !valid_q[STAGES-1] || !result_stall;
		for (int i = STAGES - 2; i >= 0; i--) begin
			load[i] = !valid_q[i] || load[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (load[0]) begin
				valid_q[0] <= item_valid;
			end
			for (int i = 1; i < STAGES; i++) begin
				if (load[i]) begin
					valid_q[i] <= valid_q[i-1];
				end
			end
		end
	end

	assign item_stall   = !load[0];
	assign result_valid = valid_q[STAGES-1];

	// Input register.
	pgdn_op_t                  op_s1, op_s2, op_s3;
	logic signed [COUNT_W-1:0] cnt_s1, cnt_s2, cnt_s3;
	logic [DAY_W-1:0]          day_s1, day_b_s1;
	logic [MONTH_W-1:0]        month_s1, month_b_s1;
	logic [YEAR_W-1:0]         year_s1, year_b_s1;

	always_ff @(posedge clk) begin
		if (load[0]) begin
			op_s1      <= pgdn_op_t'(operation);
			cnt_s1     <= day_count;
			day_s1     <= day;
			month_s1   <= month;
			year_s1    <= year;
			day_b_s1   <= day_b;
			month_b_s1 <= month_b;
			year_b_s1  <= year_b;
		end
	end

	// The operation and count ride alongside the two date-to-day stages.
	always_ff @(posedge clk) begin
		if (load[1]) begin
			op_s2  <= op_s1;
			cnt_s2 <= cnt_s1;
		end
		if (load[2]) begin
			op_s3  <= op_s2;
			cnt_s3 <= cnt_s2;
		end
	end

	logic [DAYS_W-1:0] days_a_s3, days_b_s3;
	logic              ok_a_s3, ok_b_s3;

	pgdn_date2days u_date_a (
		.clk     (clk),
		.load    (load[2:1]),
		.day     (day_s1),
		.month   (month_s1),
		.year    (year_s1),
		.days    (days_a_s3),
		.date_ok (ok_a_s3)
	);

	pgdn_date2days u_date_b (
		.clk     (clk),
		.load    (load[2:1]),
		.day     (day_b_s1),
		.month   (month_b_s1),
		.year    (year_b_s1),
		.days    (days_b_s3),
		.date_ok (ok_b_s3)
	);

	// Combine stage: pick the day number to convert back, the count to report,
	// and decide the error flag. An error clears the count here; the date
	// fields are cleared at the end by want_date.
	logic signed [24:0]        sum_c;
	logic signed [24:0]        n_c;
	logic                      in_range_c;
	logic signed [COUNT_W-1:0] diff_c;
	pgdn_side_t                side_c;
	pgdn_side_t                side_s4;
	logic [DAYS_W-1:0]         n_s4;

	always_comb begin
		sum_c      = $signed({3'b000, days_a_s3}) + $signed({{2{cnt_s3[COUNT_W-1]}}, cnt_s3});
		n_c        = (op_s3 == OP_DAYS_TO_DATE) ?
			$signed({{2{cnt_s3[COUNT_W-1]}}, cnt_s3}) : sum_c;
		in_range_c = (n_c >= 25'sd1) && (n_c <= $signed(25'(LAST_DAY)));
		diff_c     = $signed({1'b0, days_a_s3}) - $signed({1'b0, days_b_s3});

		case (op_s3)
			OP_DATE_TO_DAYS: begin
				side_c.err       = !ok_a_s3;
				side_c.count     = $signed({1'b0, days_a_s3});
				side_c.want_date = 1'b0;
			end
			OP_DAYS_TO_DATE: begin
				side_c.err       = !in_range_c;
				side_c.count     = n_c[COUNT_W-1:0];
				side_c.want_date = in_range_c;
			end
			OP_DATE_ADD: begin
				side_c.err       = !ok_a_s3 || !in_range_c;
				side_c.count     = n_c[COUNT_W-1:0];
				side_c.want_date = ok_a_s3 && in_range_c;
			end
			OP_DATE_DIFF: begin
				side_c.err       = !(ok_a_s3 && ok_b_s3);
				side_c.count     = diff_c;
				side_c.want_date = 1'b0;
			end
			default: begin
				side_c.err       = 1'b1;
				side_c.count     = '0;
				side_c.want_date = 1'b0;
			end
		endcase

		if (side_c.err) begin
			side_c.count = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (load[3]) begin
			n_s4    <= n_c[DAYS_W-1:0];
			side_s4 <= side_c;
		end
	end

	pgdn_side_t side_s10;

	pgdn_days2date u_days2date (
		.clk       (clk),
		.load      (load[9:4]),
		.n         (n_s4),
		.side      (side_s4),
		.day_s10   (out_day),
		.month_s10 (out_month),
		.year_s10  (out_year),
		.side_s10  (side_s10)
	);

	assign out_count = side_s10.count;
	assign error     = side_s10.err;

`ifndef SYNTHESIS
	// An error beat carries nothing but the flag.
	a_error_clears: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && error |->
			out_day == '0 && out_month == '0 && out_year == '0 && out_count == '0)
		else $error("error beat carries nonzero fields");

	// A produced date is a legal calendar date.
	a_date_legal: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !error && out_month != '0 |->
			out_month <= 4'd12 && out_day != '0 && out_year != '0
			&& out_year <= 14'(MAX_YEAR))
		else $error("date result out of range");

	// A produced date always comes with its positive day number.
	a_date_count: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !error && out_month != '0 |->
			out_count >= 23'sd1 && out_count <= $signed(23'(LAST_DAY)))
		else $error("date result with bad day number");
`endif

endmodule

`default_nettype wire

// ===== design/pgdn_date2days.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pgdn_date2days import pgdn_pkg::*; (
	input  wire logic               clk,
	input  wire logic [1:0]         load,
	input  wire logic [DAY_W-1:0]   day,
	input  wire logic [MONTH_W-1:0] month,
	input  wire logic [YEAR_W-1:0]  year,
	output logic      [DAYS_W-1:0]  days,
	output logic                    date_ok
);

	// Reciprocal of 25 scaled by 2^19; exact for every 14-bit dividend.
	localparam int K25_SHIFT = 19;
	localparam logic [14:0] K25 = 15'(((1 << K25_SHIFT) + 24) / 25);

	logic [YEAR_W-1:0]  p_c;
	logic [28:0]        prod25_c;
	logic [9:0]         q25_c;
	logic [4:0]         rem25_c;
	logic               leap_c;
	logic               ok_c;

	logic [YEAR_W-1:0]  p_s2;
	logic [9:0]         q25_s2;
	logic [8:0]         cum_s2;
	logic [DAY_W-1:0]   day_s2;
	logic               ok_s2;

	// First stage: year split by 25, leap rule and range check.
	always_comb begin
		p_c      = year - 14'd1;
		prod25_c = 29'(p_c) * 29'(K25);
		q25_c    = prod25_c[28:K25_SHIFT];
		rem25_c  = 5'(p_c - 14'(q25_c) * 14'd25);
		// A year is a multiple of 25 exactly when the year before leaves 24.
		leap_c   = (year[1:0] == 2'd0) && ((rem25_c != 5'd24) || (year[3:0] == 4'd0));
		ok_c     = (year != 14'd0) && (year <= 14'(MAX_YEAR))
			&& (month != 4'd0) && (month <= 4'd12)
			&& (day != 5'd0) && (day <= month_days(month, leap_c));
	end

	always_ff @(posedge clk) begin
		if (load[0]) begin
			p_s2   <= p_c;
			q25_s2 <= q25_c;
			cum_s2 <= cum_days(month, leap_c);
			day_s2 <= day;
			ok_s2  <= ok_c;
		end
	end

	// Second stage: 365*p + p/4 - p/100 + p/400 + days before month + day.
	always_ff @(posedge clk) begin
		if (load[1]) begin
			days    <= 22'(p_s2) * 22'd365 + 22'(p_s2[13:2]) - 22'(q25_s2[9:2])
				+ 22'(q25_s2[9:4]) + 22'(cum_s2) + 22'(day_s2);
			date_ok <= ok_s2;
		end
	end

endmodule

`default_nettype wire

// ===== design/pgdn_days2date.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pgdn_days2date import pgdn_pkg::*; (
	input  wire logic               clk,
	input  wire logic [5:0]         load,
	input  wire logic [DAYS_W-1:0]  n,
	input  wire pgdn_side_t         side,
	output logic      [DAY_W-1:0]   day_s10,
	output logic      [MONTH_W-1:0] month_s10,
	output logic      [YEAR_W-1:0]  year_s10,
	output pgdn_side_t              side_s10
);

	localparam int D400 = 146097;
	localparam int D100 = 36524;
	localparam int D4   = 1461;

	// Scaled reciprocals; both are exact over the ranges that reach them.
	localparam int K400_SHIFT = 40;
	localparam logic [22:0] K400 = 23'(((64'd1 << K400_SHIFT) + 64'(D400) - 64'd1) / 64'(D400));
	localparam int K4_SHIFT = 26;
	localparam logic [15:0] K4 = 16'(((64'd1 << K4_SHIFT) + 64'(D4) - 64'd1) / 64'(D4));

	logic [44:0]       prod400_c;
	logic [DAYS_W-1:0] r_c;
	logic [31:0]       prod4_c;
	logic [1:0]        q100_c;
	logic [10:0]       r4_c;
	logic [1:0]        q1_c;
	logic [MONTH_W-1:0] month_c;

	logic [DAYS_W-1:0] r_s5;
	logic [4:0]        q400_s5, q400_s6, q400_s7, q400_s8;
	logic [17:0]       r2_s6;
	logic [15:0]       r3_s7, r3_s8;
	logic [1:0]        q100_s7, q100_s8;
	logic [4:0]        q4_s8;
	logic [8:0]        r5_s9;
	logic              leap_s9;
	logic [YEAR_W-1:0] year_s9;
	pgdn_side_t        side_s5, side_s6, side_s7, side_s8, side_s9;

	// Count of whole 400-year cycles.
	always_comb begin
		r_c       = n - 22'd1;
		prod400_c = 45'(r_c) * 45'(K400);
	end

	always_ff @(posedge clk) begin
		if (load[0]) begin
			r_s5    <= r_c;
			q400_s5 <= prod400_c[K400_SHIFT+4:K400_SHIFT];
			side_s5 <= side;
		end
	end

	always_ff @(posedge clk) begin
		if (load[1]) begin
			r2_s6   <= 18'(r_s5 - 22'(q400_s5) * 22'(D400));
			q400_s6 <= q400_s5;
			side_s6 <= side_s5;
		end
	end

	// Centuries within the cycle; the last day of a cycle stays in century 3.
	always_comb begin
		if (r2_s6 >= 18'(3 * D100)) begin
			q100_c = 2'd3;
		end else if (r2_s6 >= 18'(2 * D100)) begin
			q100_c = 2'd2;
		end else if (r2_s6 >= 18'(D100)) begin
			q100_c = 2'd1;
		end else begin
			q100_c = 2'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (load[2]) begin
			r3_s7   <= 16'(r2_s6 - 18'(q100_c) * 18'(D100));
			q100_s7 <= q100_c;
			q400_s7 <= q400_s6;
			side_s7 <= side_s6;
		end
	end

	assign prod4_c = 32'(r3_s7) * 32'(K4);

	always_ff @(posedge clk) begin
		if (load[3]) begin
			q4_s8   <= prod4_c[K4_SHIFT+4:K4_SHIFT];
			r3_s8   <= r3_s7;
			q100_s8 <= q100_s7;
			q400_s8 <= q400_s7;
			side_s8 <= side_s7;
		end
	end

	// Years within the four-year group, again held at 3 on its final day.
	always_comb begin
		r4_c = 11'(r3_s8 - 16'(q4_s8) * 16'(D4));
		if (r4_c >= 11'd1095) begin
			q1_c = 2'd3;
		end else if (r4_c >= 11'd730) begin
			q1_c = 2'd2;
		end else if (r4_c >= 11'd365) begin
			q1_c = 2'd1;
		end else begin
			q1_c = 2'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (load[4]) begin
			r5_s9   <= 9'(r4_c - 11'(q1_c) * 11'd365);
			// Last year of a group is leap unless it ends a century that is not
			// the fourth of its cycle.
			leap_s9 <= (q1_c == 2'd3) && ((q4_s8 != 5'd24) || (q100_s8 == 2'd3));
			year_s9 <= 14'(q400_s8) * 14'd400 + 14'(q100_s8) * 14'd100
				+ {7'd0, q4_s8, 2'b00} + 14'(q1_c) + 14'd1;
			side_s9 <= side_s8;
		end
	end

	always_comb begin
		month_c = 4'd1;
		for (int m = 2; m <= 12; m++) begin
			if (r5_s9 >= cum_days(4'(m), leap_s9)) begin
				month_c = 4'(m);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load[5]) begin
			if (side_s9.want_date) begin
				day_s10   <= 5'(r5_s9 - cum_days(month_c, leap_s9) + 9'd1);
				month_s10 <= month_c;
				year_s10  <= year_s9;
			end else begin
				day_s10   <= '0;
				month_s10 <= '0;
				year_s10  <= '0;
			end
			side_s10 <= side_s9;
		end
	end

endmodule

`default_nettype wire
